// File: src/cda_pkg.sv
// Shared widths, constants and controller/datapath interface types for the cosine distance block.
`default_nettype none
package cda_pkg;

  localparam int ELEM_W     = 16;
  localparam int DOT_W      = 42;
  localparam int NORM_W     = 41;
  localparam int PROD_W     = 2 * NORM_W;
  localparam int ROOT_W     = NORM_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int QUO_W      = 17;
  localparam int DIST_W     = 18;
  localparam int MUL_STEPS  = NORM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 6;

  localparam logic [DIST_W-1:0] ONE_Q16  = DIST_W'(65536);
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(131072);

  typedef struct packed {
    logic acc;
    logic snap;
    logic mul_step;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: src/cda_datapath.sv
// Datapath: saturating accumulators, shift-add multiplier, bit-serial root, divider, output register.
`default_nettype none
module cda_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cda_pkg::cmd_t                       cmd_i,
  output cda_pkg::status_t                         status_o,
  input  wire logic signed [cda_pkg::ELEM_W-1:0]   elem_a_i,
  input  wire logic signed [cda_pkg::ELEM_W-1:0]   elem_b_i,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic [cda_pkg::DIST_W-1:0]               distance_o,
  output logic                                     zero_norm_o
);

  logic signed [cda_pkg::DOT_W-1:0]   dot_q;
  logic [cda_pkg::NORM_W-1:0]         na_q;
  logic [cda_pkg::NORM_W-1:0]         nb_q;

  logic signed [2*cda_pkg::ELEM_W-1:0] prod_ab;
  logic signed [2*cda_pkg::ELEM_W-1:0] sq_a;
  logic signed [2*cda_pkg::ELEM_W-1:0] sq_b;
  logic signed [cda_pkg::DOT_W:0]      dot_sum;
  logic [cda_pkg::NORM_W:0]            na_sum;
  logic [cda_pkg::NORM_W:0]            nb_sum;
  logic signed [cda_pkg::DOT_W-1:0]    dot_d;
  logic [cda_pkg::NORM_W-1:0]          na_d;
  logic [cda_pkg::NORM_W-1:0]          nb_d;

  logic signed [cda_pkg::DOT_W-1:0]   dotop_q;
  logic [cda_pkg::DOT_W-1:0]          mag_q;
  logic                               neg_q;
  logic [cda_pkg::PROD_W-1:0]         mcand_q;
  logic [cda_pkg::NORM_W-1:0]         mplier_q;
  logic [cda_pkg::PROD_W-1:0]         prod_q;
  logic [cda_pkg::REM_W-1:0]          rem_q;
  logic [cda_pkg::ROOT_W-1:0]         root_q;
  logic [cda_pkg::QUO_W-1:0]          quo_q;
  logic                               sat_q;
  logic                               lsb_q;

  logic                               out_valid_q;
  logic [cda_pkg::DIST_W-1:0]         distance_q;
  logic                               zero_q;

  logic [cda_pkg::DOT_W-1:0]          abs_dot;
  logic [cda_pkg::REM_W-1:0]          rem_sh;
  logic [cda_pkg::REM_W-1:0]          trial;
  logic                               sq_ge;
  logic [cda_pkg::ROOT_W:0]           dsh;
  logic                               d_ge;
  logic [cda_pkg::DIST_W-1:0]         cos_mag;
  logic                               root_zero;
  logic [cda_pkg::DIST_W-1:0]         dist_d;

  // accumulate with saturation
  always_comb begin
    prod_ab = elem_a_i * elem_b_i;
    sq_a    = elem_a_i * elem_a_i;
    sq_b    = elem_b_i * elem_b_i;
    dot_sum = {dot_q[cda_pkg::DOT_W-1], dot_q} + (cda_pkg::DOT_W+1)'(prod_ab);
    na_sum  = {1'b0, na_q} + (cda_pkg::NORM_W+1)'(sq_a[2*cda_pkg::ELEM_W-2:0]);
    nb_sum  = {1'b0, nb_q} + (cda_pkg::NORM_W+1)'(sq_b[2*cda_pkg::ELEM_W-2:0]);
    if (dot_sum[cda_pkg::DOT_W] != dot_sum[cda_pkg::DOT_W-1]) begin
      dot_d = dot_sum[cda_pkg::DOT_W] ? {1'b1, {(cda_pkg::DOT_W-1){1'b0}}}
                                      : {1'b0, {(cda_pkg::DOT_W-1){1'b1}}};
    end else begin
      dot_d = dot_sum[cda_pkg::DOT_W-1:0];
    end
    na_d = na_sum[cda_pkg::NORM_W] ? {cda_pkg::NORM_W{1'b1}} : na_sum[cda_pkg::NORM_W-1:0];
    nb_d = nb_sum[cda_pkg::NORM_W] ? {cda_pkg::NORM_W{1'b1}} : nb_sum[cda_pkg::NORM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.acc) begin
      if (cmd_i.snap) begin
        dot_q <= '0;
        na_q  <= '0;
        nb_q  <= '0;
      end else begin
        dot_q <= dot_d;
        na_q  <= na_d;
        nb_q  <= nb_d;
      end
    end
  end

  always_comb begin
    abs_dot = dotop_q[cda_pkg::DOT_W-1] ? cda_pkg::DOT_W'(-dotop_q) : dotop_q;
    rem_sh  = {rem_q[cda_pkg::REM_W-3:0], prod_q[cda_pkg::PROD_W-1 -: 2]};
    trial   = {root_q, 2'b01};
    sq_ge   = rem_sh >= trial;
    dsh     = {rem_q[cda_pkg::ROOT_W-1:0], lsb_q};
    d_ge    = dsh >= {1'b0, root_q};
  end

  // multiply, root and divide share the work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      dotop_q  <= dot_d;
      mcand_q  <= cda_pkg::PROD_W'(na_d);
      mplier_q <= nb_d;
      prod_q   <= '0;
      rem_q    <= '0;
      root_q   <= '0;
    end
    if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[cda_pkg::PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[cda_pkg::NORM_W-1:1]};
      mag_q    <= abs_dot;
      neg_q    <= dotop_q[cda_pkg::DOT_W-1];
    end
    if (cmd_i.sqrt_step) begin
      rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[cda_pkg::ROOT_W-2:0], sq_ge};
      prod_q <= {prod_q[cda_pkg::PROD_W-3:0], 2'b00};
    end
    if (cmd_i.div_init) begin
      sat_q <= mag_q >= {root_q, 1'b0};
      rem_q <= cda_pkg::REM_W'(mag_q[cda_pkg::DOT_W-1:1]);
      lsb_q <= mag_q[0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= cda_pkg::REM_W'(d_ge ? dsh - {1'b0, root_q} : dsh);
      quo_q <= {quo_q[cda_pkg::QUO_W-2:0], d_ge};
      lsb_q <= 1'b0;
    end
  end

  always_comb begin
    root_zero = root_q == '0;
    if (sat_q || ({1'b0, quo_q} > cda_pkg::ONE_Q16)) begin
      cos_mag = cda_pkg::ONE_Q16;
    end else begin
      cos_mag = {1'b0, quo_q};
    end
    if (root_zero) begin
      dist_d = cda_pkg::ONE_Q16;
    end else if (neg_q) begin
      dist_d = cda_pkg::ONE_Q16 + cos_mag;
    end else begin
      dist_d = cda_pkg::ONE_Q16 - cos_mag;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      distance_q <= dist_d;
      zero_q     <= root_zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;
  assign zero_norm_o = zero_q;

`ifndef SYNTHESIS
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.snap |=> (dot_q == '0) && (na_q == '0) && (nb_q == '0))
    else $error("accumulators not cleared after last transfer");
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> distance_q <= cda_pkg::DIST_MAX)
    else $error("distance out of range");
  a_zero_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && zero_q) |-> distance_q == cda_pkg::ONE_Q16)
    else $error("zero norm result not 1.0");
`endif

endmodule
`default_nettype wire

// File: src/cda_ctrl.sv
// Controller: sequences accumulate, multiply, root, divide and output load.
`default_nettype none
module cda_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_i,
  output logic                   in_ready_o,
  input  wire cda_pkg::status_t  status_i,
  output cda_pkg::cmd_t          cmd_o
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [cda_pkg::CNT_W-1:0] MUL_LAST  = cda_pkg::CNT_W'(cda_pkg::MUL_STEPS - 1);
  localparam logic [cda_pkg::CNT_W-1:0] SQRT_LAST = cda_pkg::CNT_W'(cda_pkg::SQRT_STEPS - 1);
  localparam logic [cda_pkg::CNT_W-1:0] DIV_LAST  = cda_pkg::CNT_W'(cda_pkg::DIV_STEPS - 1);

  logic [2:0]                 state_q, state_d;
  logic [cda_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
        cmd_o.snap = in_valid_i && last_i;
        if (in_valid_i && last_i) begin
          state_d = S_MUL;
          cnt_d   = '0;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = S_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == SQRT_LAST) begin
          state_d = S_DINIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
        cnt_d          = '0;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_OUT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_OUT: begin
        cmd_o.out_load = status_i.out_free;
        if (status_i.out_free) begin
          state_d = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.acc, cmd_o.mul_step, cmd_o.sqrt_step, cmd_o.div_init,
              cmd_o.div_step, cmd_o.out_load}))
    else $error("overlapping datapath commands");
  a_snap_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.snap |=> (state_q == S_MUL) && (cnt_q == '0))
    else $error("last transfer did not start multiply");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_SQRT) |-> cnt_q <= MUL_LAST)
    else $error("step counter overran");
`endif

endmodule
`default_nettype wire

// File: src/cosine_distance_accumulator_top.sv
// Top level of the streaming cosine distance accumulator.
//
// Input channel (in_valid_i/in_ready_o): one signed Q1.15 component pair per
// transfer; last_i marks the final pair of the two vectors. Pairs that are not
// last are taken one per cycle and only update the dot product and both squared
// norms, which saturate at their 42/41-bit limits.
// A last pair closes the vectors: the controller runs a shift-add multiply of the
// norms, a one-bit-per-cycle square root, a divider setup step and a restoring
// divide, then loads the output register.
// Input ready stays low from the last transfer until the output register is
// loaded, so no new pair is taken while a result is computed. distance_o is
// 1 - cosine in unsigned Q2.16; zero_norm_o flags a vector of zero norm
// (distance then 1.0).
// Output channel (out_valid_o/out_ready_i): one result held in a register.
// Accumulation of the next vectors continues while it waits; if it is still
// not taken when the next result is done, the block holds in that state.
// Reset (rst_ni low, asynchronous) clears the accumulators, the controller and
// the output valid.
`default_nettype none
module cosine_distance_accumulator_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [cda_pkg::ELEM_W-1:0]  elem_a_i,
  input  wire logic signed [cda_pkg::ELEM_W-1:0]  elem_b_i,
  input  wire logic                               last_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [cda_pkg::DIST_W-1:0]              distance_o,
  output logic                                    zero_norm_o
);

  cda_pkg::cmd_t    cmd;
  cda_pkg::status_t status;

  cda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .elem_a_i    (elem_a_i),
    .elem_b_i    (elem_b_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .distance_o  (distance_o),
    .zero_norm_o (zero_norm_o)
  );

endmodule
`default_nettype wire

// File: tb/cosine_distance_accumulator_checker.sv
// Channel monitor, cosine distance predictor and result comparison for the accumulator.
`timescale 1ns / 100ps
module cosine_distance_accumulator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [cda_pkg::ELEM_W-1:0] elem_a_i,
  input  logic signed [cda_pkg::ELEM_W-1:0] elem_b_i,
  input  logic                              last_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [cda_pkg::DIST_W-1:0]        distance_i,
  input  logic                              zero_norm_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                results_o,
  output int                                zeros_o
);

  localparam longint SUM_HI = 64'sh1FF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct packed {
    logic [cda_pkg::DIST_W-1:0] distance;
    logic                       zero_norm;
  } cos_dist_t;

  logic signed [cda_pkg::DOT_W-1:0] dot_acc;
  logic [cda_pkg::NORM_W-1:0]       norm_a_acc;
  logic [cda_pkg::NORM_W-1:0]       norm_b_acc;
  cos_dist_t                        distance_q[$];
  int                               err_cnt;
  int                               result_cnt;
  int                               zero_cnt;

  function automatic cos_dist_t distance_from_sums(longint dot,
                                                   logic [cda_pkg::NORM_W-1:0] na,
                                                   logic [cda_pkg::NORM_W-1:0] nb);
    logic [85:0] prod;
    logic [85:0] trial_sq;
    logic [42:0] root;
    logic [42:0] trial;
    logic [63:0] mag;
    logic [63:0] quot;
    longint      cos_q16;
    cos_dist_t   res;
    prod = 86'(na) * 86'(nb);
    root = '0;
    for (int i = 42; i >= 0; i--) begin
      trial = root | (43'd1 << i);
      trial_sq = 86'(trial) * 86'(trial);
      if (trial_sq <= prod) root = trial;
    end
    if (root == '0) begin
      res.distance = cda_pkg::ONE_Q16;
      res.zero_norm = 1'b1;
    end else begin
      mag = (dot < 0) ? 64'(-dot) : 64'(dot);
      quot = (mag << 16) / 64'(root);
      if (quot > 64'(cda_pkg::ONE_Q16)) quot = 64'(cda_pkg::ONE_Q16);
      cos_q16 = (dot < 0) ? -longint'(quot) : longint'(quot);
      res.distance = cda_pkg::DIST_W'(longint'(cda_pkg::ONE_Q16) - cos_q16);
      res.zero_norm = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint    dot_sum;
    longint    na_sum;
    longint    nb_sum;
    cos_dist_t want;
    if (!rst_ni) begin
      dot_acc = '0;
      norm_a_acc = '0;
      norm_b_acc = '0;
      distance_q.delete();
      err_cnt = 0;
      result_cnt = 0;
      zero_cnt = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (distance_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none expected: distance %0d zero_norm %0b",
                   $time, distance_i, zero_norm_i);
        end else begin
          want = distance_q.pop_front();
          result_cnt++;
          if (distance_i !== want.distance) begin
            err_cnt++;
            $display("%0t: distance mismatch: expected %0d, actual %0d",
                     $time, want.distance, distance_i);
          end
          if (zero_norm_i !== want.zero_norm) begin
            err_cnt++;
            $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
                     $time, want.zero_norm, zero_norm_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        dot_sum = longint'(dot_acc) + longint'(elem_a_i) * longint'(elem_b_i);
        na_sum = longint'(norm_a_acc) + longint'(elem_a_i) * longint'(elem_a_i);
        nb_sum = longint'(norm_b_acc) + longint'(elem_b_i) * longint'(elem_b_i);
        dot_acc = cda_pkg::DOT_W'((dot_sum > SUM_HI) ? SUM_HI :
                                  (dot_sum < SUM_LO) ? SUM_LO : dot_sum);
        norm_a_acc = cda_pkg::NORM_W'((na_sum > SUM_HI) ? SUM_HI : na_sum);
        norm_b_acc = cda_pkg::NORM_W'((nb_sum > SUM_HI) ? SUM_HI : nb_sum);
        if (last_i) begin
          want = distance_from_sums(longint'(dot_acc), norm_a_acc, norm_b_acc);
          distance_q.push_back(want);
          if (want.zero_norm) zero_cnt++;
          dot_acc = '0;
          norm_a_acc = '0;
          norm_b_acc = '0;
        end
      end
    end
    errors_o  <= err_cnt;
    pending_o <= distance_q.size();
    results_o <= result_cnt;
    zeros_o   <= zero_cnt;
  end

endmodule

// File: tb/cosine_distance_accumulator_top_tb.sv
// Stimulus, flow control and verdict for the cosine distance accumulator testbench.
`timescale 1ns / 100ps
module cosine_distance_accumulator_top_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PAIRS  = 1200;
  localparam int RUN_LEN     = 48;
  localparam int HOLD_START  = 300;
  localparam int HOLD_LEN    = 1000;
  localparam logic signed [cda_pkg::ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [cda_pkg::ELEM_W-1:0] ELEM_MAX = 16'sh7FFF;

  typedef enum int {
    V_RANDOM,
    V_SAME,
    V_NEG,
    V_A_ZERO,
    V_B_ZERO,
    V_TINY,
    V_CORNER
  } vec_kind_e;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [cda_pkg::ELEM_W-1:0] elem_a = '0;
  logic signed [cda_pkg::ELEM_W-1:0] elem_b = '0;
  logic                              pair_last = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [cda_pkg::DIST_W-1:0]        distance;
  logic                              zero_norm;
  logic                              hold_arm = 1'b0;
  int                                errors;
  int                                pending;
  int                                results;
  int                                zeros;
  int                                pairs_sent = 0;
  int                                burst_left = 0;
  int                                cycle_cnt = 0;
  logic signed [cda_pkg::ELEM_W-1:0] corner_val [5] =
    '{ELEM_MIN, ELEM_MAX, 16'sd0, -16'sd1, 16'sd1};

  cosine_distance_accumulator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .elem_a_i    (elem_a),
    .elem_b_i    (elem_b),
    .last_i      (pair_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .distance_o  (distance),
    .zero_norm_o (zero_norm)
  );

  cosine_distance_accumulator_checker dist_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .elem_a_i    (elem_a),
    .elem_b_i    (elem_b),
    .last_i      (pair_last),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .distance_i  (distance),
    .zero_norm_i (zero_norm),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .zeros_o     (zeros)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("cosine_distance_accumulator_top test failed");
    $finish;
  end

  initial begin : receiver
    int   mode;
    int   span;
    int   hold_cnt;
    logic rdy;
    span = 0;
    mode = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 300);
      end
      span--;
      if (hold_arm && hold_cnt < HOLD_START + HOLD_LEN) hold_cnt++;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (span % 4 == 0);
      endcase
      if (hold_cnt > HOLD_START && hold_cnt < HOLD_START + HOLD_LEN) rdy = 1'b0;
      out_ready <= rdy;
    end
  end

  task automatic send_pair(input logic signed [cda_pkg::ELEM_W-1:0] a,
                           input logic signed [cda_pkg::ELEM_W-1:0] b,
                           input logic lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    elem_a    <= a;
    elem_b    <= b;
    pair_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic send_run(input logic signed [cda_pkg::ELEM_W-1:0] a,
                          input logic signed [cda_pkg::ELEM_W-1:0] b,
                          input int len);
    for (int i = 0; i < len; i++) send_pair(a, b, i == len - 1);
  endtask

  task automatic send_vector(input vec_kind_e kind, input int len);
    logic signed [cda_pkg::ELEM_W-1:0] a;
    logic signed [cda_pkg::ELEM_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = cda_pkg::ELEM_W'($urandom);
      b = cda_pkg::ELEM_W'($urandom);
      case (kind)
        V_SAME:   b = a;
        V_NEG:    b = (a == ELEM_MIN) ? ELEM_MAX : -a;
        V_A_ZERO: a = '0;
        V_B_ZERO: b = '0;
        V_TINY: begin
          a = cda_pkg::ELEM_W'(int'($urandom_range(0, 8)) - 4);
          b = cda_pkg::ELEM_W'(int'($urandom_range(0, 8)) - 4);
        end
        V_CORNER: begin
          a = corner_val[$urandom_range(0, 4)];
          b = corner_val[$urandom_range(0, 4)];
        end
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int        rand_end;
    int        kind_sel;
    vec_kind_e kind;
    logic      paused;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(16'sd0, 16'sd12345, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd777, 16'sd0, 1'b1);
    send_pair(16'sd1000, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1000, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(-16'sd2, 16'sd7, 1'b0);
    send_pair(16'sd9, -16'sd5, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b0);
    send_pair(16'sh5555, 16'shAAAA, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    drain_results();

    hold_arm <= 1'b1;
    paused = 1'b0;
    rand_end = pairs_sent + RAND_PAIRS;
    while (pairs_sent < rand_end) begin
      kind_sel = $urandom_range(0, 9);
      kind = (kind_sel > 6) ? V_RANDOM : vec_kind_e'(kind_sel);
      send_vector(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                    : $urandom_range(1, 16));
      if (!paused && pairs_sent > rand_end - RAND_PAIRS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    drain_results();

    // long runs of pairs with a full-scale a component drive large sums
    send_run(ELEM_MIN, ELEM_MIN, RUN_LEN);
    send_run(ELEM_MIN, ELEM_MAX, RUN_LEN);
    send_run(ELEM_MIN, -16'sd1000, RUN_LEN);
    drain_results();
    repeat (150) @(posedge clk);

    $display("Checked %0d distances (%0d with a zero-norm vector) over %0d component pairs.",
             results, zeros, pairs_sent);
    $display("Ran corner pairs, random vectors, full-scale runs, bursty input, long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("cosine_distance_accumulator_top test passed");
    end else begin
      $display("cosine_distance_accumulator_top test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cda_pkg.sv
src/cda_datapath.sv
src/cda_ctrl.sv
src/cosine_distance_accumulator_top.sv
tb/cosine_distance_accumulator_checker.sv
tb/cosine_distance_accumulator_top_tb.sv
